>>> hw/rtl/itmh_pkg.sv
// ----------------------------------------------------------------------------
// itmh_pkg: shared types and constants of the indexed timer min-heap
// Field widths of the beats and the operation and status codes.
// ----------------------------------------------------------------------------
package itmh_pkg;

    localparam int OPCODE_W  = 2;
    localparam int CONN_ID_W = 10;
    localparam int TIME_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int OCC_W     = 7;

    typedef logic [OPCODE_W-1:0] t_opcode;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_opcode OP_ADD    = 2'd0;
    localparam t_opcode OP_DEL    = 2'd1;
    localparam t_opcode OP_TICK   = 2'd2;
    localparam t_opcode OP_UNUSED = 2'd3;

    localparam t_status ST_DONE      = 3'd0;
    localparam t_status ST_EXPIRED   = 3'd1;
    localparam t_status ST_NONE_DUE  = 3'd2;
    localparam t_status ST_FULL      = 3'd3;
    localparam t_status ST_NOT_FOUND = 3'd4;

endpackage

>>> hw/rtl/itmh_if.sv
// ----------------------------------------------------------------------------
// itmh_req_if / itmh_rsp_if: valid/ready channels of the timer heap
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface itmh_req_if;
    import itmh_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [OPCODE_W-1:0]  opcode;
    logic [CONN_ID_W-1:0] conn_id;
    logic [TIME_W-1:0]    expire_time;
    logic [TIME_W-1:0]    current_time;
    modport source (output valid, opcode, conn_id, expire_time, current_time, input ready);
    modport sink   (input valid, opcode, conn_id, expire_time, current_time, output ready);
endinterface

interface itmh_rsp_if;
    import itmh_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [CONN_ID_W-1:0] out_conn_id;
    logic [TIME_W-1:0]    out_expire_time;
    logic                 last;
    logic [OCC_W-1:0]     occupancy;
    modport source (output valid, status, out_conn_id, out_expire_time, last, occupancy,
                    input ready);
    modport sink   (input valid, status, out_conn_id, out_expire_time, last, occupancy,
                    output ready);
endinterface

>>> hw/rtl/indexed_timer_min_heap.sv
// ----------------------------------------------------------------------------
// indexed_timer_min_heap: connection timeout engine
// Binary min-heap of expiry times with an id-to-slot map, run by a sequencer.
// ----------------------------------------------------------------------------
// Timers live in a binary min-heap ordered by expiry, and a position map from
// connection id to heap slot lets an existing timer be found without a search.
// Opcode 0 adds a timer or rewrites its expiry, opcode 1 deletes it and opcode
// 2 pops every timer that is due at the given time, one response beat per pop
// with last on the final one. One item is worked at a time and the request
// channel is not ready meanwhile. The cost is set by the single heap memory
// port and the one shared comparator: a lookup reads the position map, and a
// sift walks the heap one level at a time, reading both children and then
// comparing going down, and reading the parent and comparing going up. A tick
// pops each due timer at the root and sifts the last entry down in its place.
// After reset the position map is cleared one id a cycle, and the block is not
// ready until every id is cleared. The response channel has an output register,
// so a finished beat may wait for its consumer while the block carries on.
// ----------------------------------------------------------------------------
module indexed_timer_min_heap
    import itmh_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int ID_COUNT  = 1024,
    parameter int TIME_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    itmh_req_if.sink     i_req,
    itmh_rsp_if.source   o_rsp
);
    // Key width: expiries are kept to TIME_BITS, at most the 32 bits the fields carry.
    localparam int KW  = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
    localparam int EW  = KW + CONN_ID_W;           // heap entry: {key, id}
    localparam int SW  = $clog2(CAPACITY);         // slot index
    localparam int CW  = $clog2(CAPACITY + 1);     // occupancy count
    localparam int PW  = SW + 2;                   // room for child slot sums
    localparam int IDW = $clog2(ID_COUNT);         // position map index
    localparam int MW  = SW + 1;                   // map word: {present, slot}

    typedef enum logic [4:0] {
        S_IDLE, S_EMIT, S_ADD_LK, S_DEL_LK, S_DEL_RD, S_DEL_MV,
        S_DN, S_DN_C1, S_DN_C2, S_DN_CMP, S_UP, S_UP_CMP, S_PLACE,
        S_T_CHK, S_T_CMP, S_T_POP, S_T_MV, S_T_END
    } t_state;

    t_state                r_state;
    t_opcode               r_op;
    logic [CONN_ID_W-1:0]  r_id;
    logic [KW-1:0]         r_exp;
    logic [KW-1:0]         r_cur;
    logic [CW-1:0]         r_size;
    logic [SW-1:0]         r_h;        // the hole the moving entry may take
    logic [SW-1:0]         r_t;        // chosen child slot
    logic [EW-1:0]         r_m;        // the moving entry
    logic [EW-1:0]         r_c;        // chosen child entry
    logic [EW-1:0]         r_top;      // root found due on a tick
    logic [EW-1:0]         r_pend;     // popped timer whose beat is not yet sent
    logic                  r_pend_v;
    logic                  r_moved;
    logic                  r_up_after;
    t_status               r_st;
    logic [KW-1:0]         r_oexp;

    logic                  r_ovalid;
    t_status               r_ost;
    logic [CONN_ID_W-1:0]  r_oid;
    logic [TIME_W-1:0]     r_otime;
    logic                  r_olast;
    logic [OCC_W-1:0]      r_oocc;

    logic                  hp_we;
    logic [SW-1:0]         hp_waddr;
    logic [EW-1:0]         hp_wdata;
    logic [SW-1:0]         hp_raddr;
    logic [EW-1:0]         hp_rdata;
    logic                  sm_we;
    logic [IDW-1:0]        sm_waddr;
    logic [MW-1:0]         sm_wdata;
    logic [IDW-1:0]        sm_raddr;
    logic [MW-1:0]         sm_rdata;
    logic                  sm_busy;

    logic [KW-1:0]         cmp_a;
    logic [KW-1:0]         cmp_b;
    logic                  cmp_lt;

    logic                  out_free;
    logic                  in_fire;
    logic                  id_oor;
    logic [PW-1:0]         c1;
    logic [PW-1:0]         sz_p;
    logic [SW-1:0]         parent;
    logic [CW-1:0]         size_m1;
    logic                  sm_present;
    logic [SW-1:0]         sm_slot;

    itmh_heap_ram #(.DEPTH(CAPACITY), .AW(SW), .DW(EW)) u_heap (
        .i_clk   (i_clk),
        .i_we    (hp_we),
        .i_waddr (hp_waddr),
        .i_wdata (hp_wdata),
        .i_raddr (hp_raddr),
        .o_rdata (hp_rdata)
    );

    itmh_slot_ram #(.DEPTH(ID_COUNT), .AW(IDW), .DW(MW)) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (sm_we),
        .i_waddr (sm_waddr),
        .i_wdata (sm_wdata),
        .i_raddr (sm_raddr),
        .o_rdata (sm_rdata),
        .o_busy  (sm_busy)
    );

    assign out_free   = !r_ovalid || o_rsp.ready;
    assign in_fire    = i_req.valid && i_req.ready;
    assign id_oor     = (32'(i_req.conn_id) >= ID_COUNT);
    assign c1         = {1'b0, r_h, 1'b1};
    assign sz_p       = PW'(r_size);
    assign parent     = (r_h - 1'b1) >> 1;
    assign size_m1    = r_size - 1'b1;
    assign sm_present = sm_rdata[MW-1];
    assign sm_slot    = sm_rdata[SW-1:0];

    assign i_req.ready           = (r_state == S_IDLE) && !sm_busy;
    assign o_rsp.valid           = r_ovalid;
    assign o_rsp.status          = r_ost;
    assign o_rsp.out_conn_id     = r_oid;
    assign o_rsp.out_expire_time = r_otime;
    assign o_rsp.last            = r_olast;
    assign o_rsp.occupancy       = r_oocc;

    // The one comparator, shared by every key compare the sequencer makes.
    always_comb begin
        cmp_a = r_m[EW-1:CONN_ID_W];
        cmp_b = r_c[EW-1:CONN_ID_W];
        case (r_state)
            S_DN_C2: begin
                cmp_a = hp_rdata[EW-1:CONN_ID_W];
            end
            S_UP_CMP: begin
                cmp_b = hp_rdata[EW-1:CONN_ID_W];
            end
            S_T_CMP: begin
                cmp_a = r_cur;
                cmp_b = hp_rdata[EW-1:CONN_ID_W];
            end
            default: begin
            end
        endcase
    end
    assign cmp_lt = (cmp_a < cmp_b);

    // Memory addresses and writes follow from the state.
    always_comb begin
        hp_we    = 1'b0;
        hp_waddr = r_h;
        hp_wdata = r_m;
        hp_raddr = '0;
        sm_we    = 1'b0;
        sm_waddr = IDW'(r_m[CONN_ID_W-1:0]);
        sm_wdata = {1'b1, r_h};
        sm_raddr = IDW'(i_req.conn_id);
        unique case (r_state)
            S_DEL_LK: begin
                hp_raddr = sm_slot;
                sm_we    = sm_present;
                sm_waddr = IDW'(r_id);
                sm_wdata = '0;
            end
            S_DEL_RD: begin
                hp_raddr = SW'(size_m1);
            end
            S_DN: begin
                hp_raddr = SW'(c1);
            end
            S_DN_C1: begin
                hp_raddr = SW'(c1 + 1'b1);
            end
            S_DN_CMP: begin
                if (!cmp_lt) begin
                    hp_we    = 1'b1;
                    hp_wdata = r_c;
                    sm_we    = 1'b1;
                    sm_waddr = IDW'(r_c[CONN_ID_W-1:0]);
                end
            end
            S_UP: begin
                hp_raddr = parent;
            end
            S_UP_CMP: begin
                if (cmp_lt) begin
                    hp_we    = 1'b1;
                    hp_wdata = hp_rdata;
                    sm_we    = 1'b1;
                    sm_waddr = IDW'(hp_rdata[CONN_ID_W-1:0]);
                end
            end
            S_PLACE: begin
                hp_we = 1'b1;
                sm_we = 1'b1;
            end
            S_T_POP: begin
                hp_raddr = SW'(size_m1);
                sm_we    = !r_pend_v || out_free;
                sm_waddr = IDW'(r_top[CONN_ID_W-1:0]);
                sm_wdata = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_size   <= '0;
            r_ovalid <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_op     <= i_req.opcode;
                        r_id     <= i_req.conn_id;
                        r_exp    <= KW'(i_req.expire_time);
                        r_cur    <= KW'(i_req.current_time);
                        r_oexp   <= '0;
                        r_st     <= ST_DONE;
                        r_pend_v <= 1'b0;
                        unique case (i_req.opcode) inside
                            OP_ADD, OP_DEL: begin
                                if (id_oor) begin
                                    r_st    <= ST_NOT_FOUND;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_state <= (i_req.opcode == OP_ADD) ? S_ADD_LK : S_DEL_LK;
                                end
                            end
                            OP_TICK: begin
                                r_state <= S_T_CHK;
                            end
                            default: begin
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ost    <= r_st;
                        r_oid    <= r_id;
                        r_otime  <= TIME_W'(r_oexp);
                        r_olast  <= 1'b1;
                        r_oocc   <= OCC_W'(r_size);
                        r_state  <= S_IDLE;
                    end
                end
                S_ADD_LK: begin
                    r_m        <= {r_exp, r_id};
                    r_moved    <= 1'b0;
                    r_up_after <= 1'b1;
                    if (sm_present) begin
                        r_h     <= sm_slot;
                        r_oexp  <= r_exp;
                        r_state <= S_DN;
                    end else if (r_size == CW'(CAPACITY)) begin
                        r_st    <= ST_FULL;
                        r_state <= S_EMIT;
                    end else begin
                        r_h     <= SW'(r_size);
                        r_size  <= r_size + 1'b1;
                        r_oexp  <= r_exp;
                        r_state <= S_UP;
                    end
                end
                S_DEL_LK: begin
                    r_h <= sm_slot;
                    if (sm_present) begin
                        r_state <= S_DEL_RD;
                    end else begin
                        r_st    <= ST_NOT_FOUND;
                        r_state <= S_EMIT;
                    end
                end
                S_DEL_RD: begin
                    // The last entry fills the freed slot, unless it was that slot.
                    r_oexp <= hp_rdata[EW-1:CONN_ID_W];
                    r_size <= size_m1;
                    if (PW'(r_h) == PW'(size_m1)) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_DEL_MV;
                    end
                end
                S_DEL_MV: begin
                    r_m        <= hp_rdata;
                    r_moved    <= 1'b0;
                    r_up_after <= 1'b1;
                    r_state    <= S_DN;
                end
                S_DN: begin
                    if (c1 >= sz_p) begin
                        r_state <= (r_moved || !r_up_after) ? S_PLACE : S_UP;
                    end else begin
                        r_t     <= SW'(c1);
                        r_state <= S_DN_C1;
                    end
                end
                S_DN_C1: begin
                    r_c     <= hp_rdata;
                    r_state <= ((c1 + 1'b1) < sz_p) ? S_DN_C2 : S_DN_CMP;
                end
                S_DN_C2: begin
                    // Right child wins only when strictly smaller.
                    if (cmp_lt) begin
                        r_c <= hp_rdata;
                        r_t <= r_t + 1'b1;
                    end
                    r_state <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    // Equal keys move the child up, as a swap on ties would.
                    if (cmp_lt) begin
                        r_state <= (r_moved || !r_up_after) ? S_PLACE : S_UP;
                    end else begin
                        r_h     <= r_t;
                        r_moved <= 1'b1;
                        r_state <= S_DN;
                    end
                end
                S_UP: begin
                    r_state <= (r_h == '0) ? S_PLACE : S_UP_CMP;
                end
                S_UP_CMP: begin
                    if (cmp_lt) begin
                        r_h     <= parent;
                        r_state <= S_UP;
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    r_state <= (r_op == OP_TICK) ? S_T_CHK : S_EMIT;
                end
                S_T_CHK: begin
                    r_state <= (r_size == '0) ? S_T_END : S_T_CMP;
                end
                S_T_CMP: begin
                    // Due when the present time is not below the expiry.
                    if (!cmp_lt) begin
                        r_top   <= hp_rdata;
                        r_state <= S_T_POP;
                    end else begin
                        r_state <= S_T_END;
                    end
                end
                S_T_POP: begin
                    if (!r_pend_v || out_free) begin
                        if (r_pend_v) begin
                            r_ovalid <= 1'b1;
                            r_ost    <= ST_EXPIRED;
                            r_oid    <= r_pend[CONN_ID_W-1:0];
                            r_otime  <= TIME_W'(r_pend[EW-1:CONN_ID_W]);
                            r_olast  <= 1'b0;
                            r_oocc   <= OCC_W'(r_size);
                        end
                        r_pend   <= r_top;
                        r_pend_v <= 1'b1;
                        r_size   <= size_m1;
                        r_state  <= (size_m1 == '0) ? S_T_CHK : S_T_MV;
                    end
                end
                S_T_MV: begin
                    r_m        <= hp_rdata;
                    r_h        <= '0;
                    r_moved    <= 1'b0;
                    r_up_after <= 1'b0;
                    r_state    <= S_DN;
                end
                S_T_END: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_olast  <= 1'b1;
                        r_oocc   <= OCC_W'(r_size);
                        if (r_pend_v) begin
                            r_ost   <= ST_EXPIRED;
                            r_oid   <= r_pend[CONN_ID_W-1:0];
                            r_otime <= TIME_W'(r_pend[EW-1:CONN_ID_W]);
                        end else begin
                            r_ost   <= ST_NONE_DUE;
                            r_oid   <= '0;
                            r_otime <= '0;
                        end
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

>>> hw/rtl/itmh_heap_ram.sv
// ----------------------------------------------------------------------------
// itmh_heap_ram: heap slot storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module itmh_heap_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 42
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

>>> hw/rtl/itmh_slot_ram.sv
// ----------------------------------------------------------------------------
// itmh_slot_ram: position map from connection id to heap slot
// Each word holds a present flag and a slot. After reset a clearing pass
// writes every word to zero, one a cycle, while o_busy is high.
// ----------------------------------------------------------------------------
module itmh_slot_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata,
    output logic          o_busy
);
    logic [DW-1:0] mem [DEPTH];
    logic          r_busy;
    logic [AW-1:0] r_ix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_ix   <= '0;
        end else if (r_busy) begin
            r_ix <= r_ix + 1'b1;
            if (r_ix == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_ix] <= '0;
        end else if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

    assign o_busy = r_busy;
endmodule

>>> hw/rtl/itmh_checker.sv
// ----------------------------------------------------------------------------
// itmh_checker: port-level checks on the timer heap's response beats
// Bound to the top level; reports through $error.
// ----------------------------------------------------------------------------
module itmh_checker
    import itmh_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 i_ready,
    input logic [STATUS_W-1:0]  i_status,
    input logic [CONN_ID_W-1:0] i_id,
    input logic [TIME_W-1:0]    i_time,
    input logic                 i_last,
    input logic [OCC_W-1:0]     i_occ
);
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (32'(i_occ) <= CAPACITY))
        else $error("occupancy above capacity");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status != ST_EXPIRED) |-> i_last)
        else $error("non-pop beat without last");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == ST_NONE_DUE) |-> (i_id == '0) && (i_time == '0))
        else $error("nothing-due beat carries data");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && (i_status == ST_EXPIRED) && !i_last |=>
            !i_valid || (i_status == ST_EXPIRED))
        else $error("tick burst interrupted");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_status) && $stable(i_id)
            && $stable(i_time) && $stable(i_last) && $stable(i_occ))
        else $error("stalled beat changed");
endmodule

bind indexed_timer_min_heap itmh_checker #(.CAPACITY(CAPACITY)) u_itmh_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_rsp.valid),
    .i_ready  (o_rsp.ready),
    .i_status (o_rsp.status),
    .i_id     (o_rsp.out_conn_id),
    .i_time   (o_rsp.out_expire_time),
    .i_last   (o_rsp.last),
    .i_occ    (o_rsp.occupancy)
);
